@@ rtl/iox_pkg.sv @@
package iox_pkg;

  // Seven-bit base address; the strap value is added to it
  localparam logic [6:0] BASE_ADDRESS = 7'h20;

  // Reset values of the register file
  localparam logic [7:0] OUT_LATCH_RESET = 8'hFF;
  localparam logic [7:0] INVERT_RESET    = 8'h00;
  localparam logic [7:0] DIRECTION_RESET = 8'hFF;
  localparam logic [7:0] CAPTURE_RESET   = 8'h00;

  // Level of a released bus, returned on a read while not addressed
  localparam logic [7:0] IDLE_BUS_BYTE = 8'hFF;

  // Event codes
  localparam logic [2:0] OP_ADDRESS = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_PIN_CHG = 3'd4;

  // Register pointer codes
  localparam logic [1:0] PTR_INPUT     = 2'd0;
  localparam logic [1:0] PTR_OUTPUT    = 2'd1;
  localparam logic [1:0] PTR_POLARITY  = 2'd2;
  localparam logic [1:0] PTR_DIRECTION = 2'd3;

  // Highest valid pointer byte
  localparam logic [7:0] POINTER_MAX = 8'h03;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] bus_address;
    logic       is_read;
    logic [7:0] write_data;
    logic [7:0] pins_in;
  } item_t;

  typedef struct packed {
    logic       ack;
    logic [7:0] read_data;
    logic [7:0] drive_level;
    logic [7:0] drive_enable;
    logic       int_active;
  } result_t;

  // Port value: pin level for input pins, latched bit for output pins
  function automatic logic [7:0] port_value(input logic [7:0] pins,
                                            input logic [7:0] dir,
                                            input logic [7:0] latch);
    port_value = (pins & dir) | (latch & ~dir);
  endfunction

endpackage

@@ rtl/iox_regs.sv @@
module iox_regs
  import iox_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  item_t      item,
  input  logic [2:0] addr_select,
  output result_t    result
);

  logic [1:0] pointer;
  logic [1:0] pointer_next;
  logic       expect_pointer;
  logic       expect_pointer_next;
  logic       addressed;
  logic       addressed_next;
  logic [7:0] out_latch;
  logic [7:0] out_latch_next;
  logic [7:0] invert_mask;
  logic [7:0] invert_mask_next;
  logic [7:0] direction;
  logic [7:0] direction_next;
  logic [7:0] captured_port;
  logic [7:0] captured_port_next;
  logic       int_flag;
  logic       int_flag_next;

  logic       do_refresh;
  logic       ack_c;
  logic [7:0] rd_c;
  logic [7:0] port_now;
  logic [7:0] port_after;
  logic [6:0] my_address;
  logic       int_eval;

  assign my_address = BASE_ADDRESS + {4'd0, addr_select};
  assign port_now   = port_value(item.pins_in, direction, out_latch);

  // Decode the event and form the next register values
  always_comb begin
    pointer_next        = pointer;
    expect_pointer_next = expect_pointer;
    addressed_next      = addressed;
    out_latch_next      = out_latch;
    invert_mask_next    = invert_mask;
    direction_next      = direction;
    captured_port_next  = captured_port;
    do_refresh          = 1'b0;
    ack_c               = 1'b0;
    rd_c                = 8'h00;
    unique case (item.op)
      OP_ADDRESS: begin
        if (item.bus_address == my_address) begin
          addressed_next = 1'b1;
          ack_c          = 1'b1;
          if (!item.is_read) begin
            expect_pointer_next = 1'b1;
          end
        end else begin
          addressed_next = 1'b0;
        end
      end
      OP_WRITE: begin
        if (addressed) begin
          if (expect_pointer) begin
            if (item.write_data <= POINTER_MAX) begin
              pointer_next        = item.write_data[1:0];
              expect_pointer_next = 1'b0;
              ack_c               = 1'b1;
            end
          end else begin
            ack_c = 1'b1;
            unique case (pointer)
              PTR_INPUT:     ;
              PTR_OUTPUT:    out_latch_next   = item.write_data;
              PTR_POLARITY:  invert_mask_next = item.write_data;
              PTR_DIRECTION: direction_next   = item.write_data;
              default:       ;
            endcase
            do_refresh = (pointer != PTR_INPUT);
          end
        end
      end
      OP_READ: begin
        if (!addressed) begin
          rd_c = IDLE_BUS_BYTE;
        end else begin
          unique case (pointer)
            PTR_INPUT: begin
              captured_port_next = port_now;
              rd_c               = port_now ^ invert_mask;
            end
            PTR_OUTPUT:    rd_c = out_latch;
            PTR_POLARITY:  rd_c = invert_mask;
            PTR_DIRECTION: rd_c = direction;
            default:       rd_c = direction;
          endcase
        end
      end
      OP_STOP: begin
        addressed_next      = 1'b0;
        expect_pointer_next = 1'b1;
      end
      OP_PIN_CHG: begin
        do_refresh = 1'b1;
      end
      default: ;
    endcase
  end

  // Compare input pins against the captured value using the updated registers
  assign port_after = port_value(item.pins_in, direction_next, out_latch_next);
  assign int_eval   = |((port_after ^ captured_port) & direction_next);

  always_comb begin
    int_flag_next = int_flag;
    if (do_refresh) begin
      int_flag_next = int_eval;
    end else if (item.op == OP_READ && addressed && pointer == PTR_INPUT) begin
      int_flag_next = 1'b0;
    end
  end

  // Result reflects the state after this event
  assign result.ack          = ack_c;
  assign result.read_data    = rd_c;
  assign result.drive_level  = out_latch_next;
  assign result.drive_enable = ~direction_next;
  assign result.int_active   = int_flag_next;

  // Commit state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pointer        <= PTR_INPUT;
      expect_pointer <= 1'b1;
      addressed      <= 1'b0;
      out_latch      <= OUT_LATCH_RESET;
      invert_mask    <= INVERT_RESET;
      direction      <= DIRECTION_RESET;
      captured_port  <= CAPTURE_RESET;
      int_flag       <= 1'b0;
    end else if (fire) begin
      pointer        <= pointer_next;
      expect_pointer <= expect_pointer_next;
      addressed      <= addressed_next;
      out_latch      <= out_latch_next;
      invert_mask    <= invert_mask_next;
      direction      <= direction_next;
      captured_port  <= captured_port_next;
      int_flag       <= int_flag_next;
    end
  end

  a_read_input_clears_int: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == OP_READ && addressed && pointer == PTR_INPUT |=> !int_flag)
    else $error("input register read did not clear interrupt");

  a_stop_releases: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == OP_STOP |=> !addressed && expect_pointer)
    else $error("stop did not release the device");

  a_refused_pointer_holds: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == OP_WRITE && expect_pointer && item.write_data > POINTER_MAX
    |=> $stable(pointer) && expect_pointer)
    else $error("refused pointer byte changed the pointer");

  a_unaddressed_write_holds: assert property (@(posedge clk) disable iff (rst)
    fire && item.op == OP_WRITE && !addressed
    |=> $stable(out_latch) && $stable(invert_mask) && $stable(direction))
    else $error("write while not addressed changed a register");

endmodule

@@ rtl/i2c_gpio_expander_8bit_core.sv @@
// Channel   Handshake                Payload
// input     in_valid / in_stall      op, bus_address, is_read, write_data, pins_in
// output    out_valid / out_stall    ack, read_data, drive_level, drive_enable, int_active
// config    cfg_wr_en                cfg_wr_data (addr_select)
//
// An event passes through the input register and then the result register before
// its result is presented. One event is accepted per cycle while in_stall is low.
// The register file updates as an event moves from the input register to the
// result register. Synchronous reset empties both stages and loads register
// defaults. A stalled result holds the input register, which then stalls input.
module i2c_gpio_expander_8bit_core
  import iox_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  input  logic [6:0] bus_address,
  input  logic       is_read,
  input  logic [7:0] write_data,
  input  logic [7:0] pins_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       ack,
  output logic [7:0] read_data,
  output logic [7:0] drive_level,
  output logic [7:0] drive_enable,
  output logic       int_active
);

  logic [2:0] addr_select;
  logic       s1_valid;
  item_t      s1_item;
  logic       s1_move;
  logic       in_take;
  result_t    res_c;
  result_t    res_q;

  // Strap register
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_select <= 3'd0;
    end else if (cfg_wr_en) begin
      addr_select <= cfg_wr_data;
    end
  end

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= '{op: op, bus_address: bus_address, is_read: is_read,
                   write_data: write_data, pins_in: pins_in};
    end
  end

  iox_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_move),
    .item        (s1_item),
    .addr_select (addr_select),
    .result      (res_c)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_q <= res_c;
    end
  end

  assign ack          = res_q.ack;
  assign read_data    = res_q.read_data;
  assign drive_level  = res_q.drive_level;
  assign drive_enable = res_q.drive_enable;
  assign int_active   = res_q.int_active;

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid)
    else $error("pending event dropped from input register");

  a_ack_vs_read: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ack && read_data != 8'h00))
    else $error("ack and read data both set in one result");

  a_result_follows_move: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("event moved but no result presented");

endmodule
